### hw/rtl/btcsc_pkg.sv
// Shared types, coefficients and word layouts for the Rec.709 color space converter.
`default_nettype none

package btcsc_pkg;

  // Direction register codes.
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  // Fixed point layout: coefficients carry 14 fraction bits, chroma/luma carry 8.
  localparam int COEF_FRAC  = 14;
  localparam int FWD_SHIFT  = 6;
  localparam int INV_SHIFT  = 22;
  localparam int FWD_PROD_W = 24;
  localparam int FWD_SUM_W  = 26;
  localparam int INV_PROD_W = 32;
  localparam int INV_SUM_W  = 34;

  typedef logic signed [FWD_PROD_W-1:0] fwd_prod_t;
  typedef logic signed [FWD_SUM_W-1:0]  fwd_sum_t;
  typedef logic signed [INV_PROD_W-1:0] inv_prod_t;
  typedef logic signed [INV_SUM_W-1:0]  inv_sum_t;

  // Forward coefficients in Q2.14.
  localparam fwd_prod_t Y_R  = 24'sd3483;
  localparam fwd_prod_t Y_G  = 24'sd11718;
  localparam fwd_prod_t Y_B  = 24'sd1183;
  localparam fwd_prod_t CB_R = -24'sd1877;
  localparam fwd_prod_t CB_G = -24'sd6315;
  localparam fwd_prod_t CB_B = 24'sd8192;
  localparam fwd_prod_t CR_R = 24'sd8192;
  localparam fwd_prod_t CR_G = -24'sd7441;
  localparam fwd_prod_t CR_B = -24'sd751;

  // Inverse coefficients in Q2.14.
  localparam inv_prod_t R_CR = 32'sd25802;
  localparam inv_prod_t G_CB = -32'sd3069;
  localparam inv_prod_t G_CR = -32'sd7669;
  localparam inv_prod_t B_CB = 32'sd30402;

  // Input word, red in the lowest bits.
  typedef struct packed {
    logic [7:0]         alpha;
    logic signed [15:0] red_diff;
    logic signed [15:0] blue_diff;
    logic [15:0]        luma;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } pix_in_t;

  // Output word, luma in the lowest bits.
  typedef struct packed {
    logic [7:0]         alpha;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [15:0] red_diff;
    logic signed [15:0] blue_diff;
    logic [15:0]        luma;
  } pix_out_t;

  // Control that travels alongside each pipeline stage.
  typedef struct packed {
    logic       valid;
    logic       dir;
    logic [7:0] alpha;
  } btcsc_ctl_t;

  // Products registered after the multiply stage.
  typedef struct packed {
    fwd_prod_t y_r;
    fwd_prod_t y_g;
    fwd_prod_t y_b;
    fwd_prod_t cb_r;
    fwd_prod_t cb_g;
    fwd_prod_t cb_b;
    fwd_prod_t cr_r;
    fwd_prod_t cr_g;
    fwd_prod_t cr_b;
    inv_prod_t y;
    inv_prod_t r_cr;
    inv_prod_t g_cb;
    inv_prod_t g_cr;
    inv_prod_t b_cb;
  } btcsc_prod_t;

  // Sums registered after the adder stage.
  typedef struct packed {
    fwd_sum_t luma;
    fwd_sum_t blue_diff;
    fwd_sum_t red_diff;
    inv_sum_t red;
    inv_sum_t green;
    inv_sum_t blue;
  } btcsc_sum_t;

endpackage

`default_nettype wire

### hw/rtl/bt709_color_space_converter.sv
// An accepted input word passes three registered stages to its output: multiply, add, round.
// Throughput: one word per cycle; the three stages advance together whenever the output
// register is empty or its word is being taken, so the input is ready in that same cycle.
// Reset: rst synchronously clears all stage valid bits and sets the direction to RGB to YCbCr.
// Data registers are not reset.
`default_nettype none

module bt709_color_space_converter
  import btcsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Direction register: 0 converts RGB to YCbCr, 1 converts YCbCr to RGB.
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16], luma_in[39:24],
  // blue_diff_in[55:40], red_diff_in[71:56], alpha_in[79:72]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // luma_out[15:0], blue_diff_out[31:16], red_diff_out[47:32], red_out[55:48],
  // green_out[63:56], blue_out[71:64], alpha_out[79:72]
  output logic [79:0]      m_axis_tdata
);

  logic        direction;
  logic        adv;
  pix_in_t     pix_in;
  pix_out_t    pix_out;
  btcsc_ctl_t  ctl_mult;
  btcsc_ctl_t  ctl_sum;
  btcsc_prod_t prod;
  btcsc_sum_t  sums;

  // Direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_FWD;
    end else if (cfg_wen) begin
      direction <= cfg_wdata;
    end
  end

  // The whole pipeline moves when the output register can take a new word.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign pix_in        = pix_in_t'(s_axis_tdata);
  assign m_axis_tdata  = pix_out;

  btcsc_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid),
    .in_dir   (direction),
    .pix      (pix_in),
    .ctl_out  (ctl_mult),
    .prod_out (prod)
  );

  btcsc_sum u_sum (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (ctl_mult),
    .prod_in (prod),
    .ctl_out (ctl_sum),
    .sum_out (sums)
  );

  btcsc_round u_round (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (ctl_sum),
    .sum_in    (sums),
    .out_valid (m_axis_tvalid),
    .pix_out   (pix_out)
  );

  // A word accepted while the pipeline keeps moving shows up at the output.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 s_axis_tready ##1 s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word did not reach the output after three cycles");

  // Only the channels of one direction may be nonzero in an output word.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pix_out.red == 8'd0 && pix_out.green == 8'd0 && pix_out.blue == 8'd0)
                   || (pix_out.luma == 16'd0 && pix_out.blue_diff == 16'sd0
                       && pix_out.red_diff == 16'sd0))
    else $error("output word mixes forward and inverse channels");

  // The output valid bit only rises when the pipeline was allowed to advance.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("output valid rose while the pipeline was stalled");

endmodule

`default_nettype wire

### hw/rtl/btcsc_mult.sv
// First pipeline stage: all constant coefficient products for both directions.
`default_nettype none

module btcsc_mult
  import btcsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic        in_dir,
  input  wire pix_in_t     pix,
  output btcsc_ctl_t       ctl_out,
  output btcsc_prod_t      prod_out
);

  logic        valid;
  logic        dir;
  logic [7:0]  alpha;
  btcsc_prod_t prod;

  fwd_prod_t r_ext;
  fwd_prod_t g_ext;
  fwd_prod_t b_ext;
  inv_prod_t cb_ext;
  inv_prod_t cr_ext;

  // Widen the operands to the product widths.
  assign r_ext  = fwd_prod_t'(pix.red);
  assign g_ext  = fwd_prod_t'(pix.green);
  assign b_ext  = fwd_prod_t'(pix.blue);
  assign cb_ext = inv_prod_t'(pix.blue_diff);
  assign cr_ext = inv_prod_t'(pix.red_diff);

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  // Products and side data.
  always_ff @(posedge clk) begin
    if (adv) begin
      dir       <= in_dir;
      alpha     <= pix.alpha;
      prod.y_r  <= r_ext * Y_R;
      prod.y_g  <= g_ext * Y_G;
      prod.y_b  <= b_ext * Y_B;
      prod.cb_r <= r_ext * CB_R;
      prod.cb_g <= g_ext * CB_G;
      prod.cb_b <= b_ext * CB_B;
      prod.cr_r <= r_ext * CR_R;
      prod.cr_g <= g_ext * CR_G;
      prod.cr_b <= b_ext * CR_B;
      prod.y    <= inv_prod_t'({pix.luma, {COEF_FRAC{1'b0}}});
      prod.r_cr <= cr_ext * R_CR;
      prod.g_cb <= cb_ext * G_CB;
      prod.g_cr <= cr_ext * G_CR;
      prod.b_cb <= cb_ext * B_CB;
    end
  end

  assign ctl_out  = '{valid: valid, dir: dir, alpha: alpha};
  assign prod_out = prod;

endmodule

`default_nettype wire

### hw/rtl/btcsc_sum.sv
// Second pipeline stage: adds the products of each output channel.
`default_nettype none

module btcsc_sum
  import btcsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire btcsc_ctl_t  ctl_in,
  input  wire btcsc_prod_t prod_in,
  output btcsc_ctl_t       ctl_out,
  output btcsc_sum_t       sum_out
);

  logic       valid;
  logic       dir;
  logic [7:0] alpha;
  btcsc_sum_t sums;

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= ctl_in.valid;
    end
  end

  // Two- and three-term sums, sign extended to the sum widths.
  always_ff @(posedge clk) begin
    if (adv) begin
      dir            <= ctl_in.dir;
      alpha          <= ctl_in.alpha;
      sums.luma      <= fwd_sum_t'($signed(prod_in.y_r)) + fwd_sum_t'($signed(prod_in.y_g))
                      + fwd_sum_t'($signed(prod_in.y_b));
      sums.blue_diff <= fwd_sum_t'($signed(prod_in.cb_r)) + fwd_sum_t'($signed(prod_in.cb_g))
                      + fwd_sum_t'($signed(prod_in.cb_b));
      sums.red_diff  <= fwd_sum_t'($signed(prod_in.cr_r)) + fwd_sum_t'($signed(prod_in.cr_g))
                      + fwd_sum_t'($signed(prod_in.cr_b));
      sums.red       <= inv_sum_t'($signed(prod_in.y)) + inv_sum_t'($signed(prod_in.r_cr));
      sums.green     <= inv_sum_t'($signed(prod_in.y)) + inv_sum_t'($signed(prod_in.g_cb))
                      + inv_sum_t'($signed(prod_in.g_cr));
      sums.blue      <= inv_sum_t'($signed(prod_in.y)) + inv_sum_t'($signed(prod_in.b_cb));
    end
  end

  assign ctl_out = '{valid: valid, dir: dir, alpha: alpha};
  assign sum_out = sums;

endmodule

`default_nettype wire

### hw/rtl/btcsc_round.sv
// Third pipeline stage: rounding, clamping and the output register.
`default_nettype none

module btcsc_round
  import btcsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire btcsc_ctl_t ctl_in,
  input  wire btcsc_sum_t sum_in,
  output logic            out_valid,
  output pix_out_t        pix_out
);

  localparam fwd_sum_t FWD_HALF = fwd_sum_t'(1) <<< (FWD_SHIFT - 1);
  localparam inv_sum_t INV_HALF = inv_sum_t'(1) <<< (INV_SHIFT - 1);
  localparam inv_sum_t INV_TOP  = inv_sum_t'(255) <<< INV_SHIFT;

  logic     valid;
  pix_out_t pix;
  pix_out_t pix_next;

  // Round to nearest with ties up, keeping the low 16 bits of the result.
  function automatic logic [15:0] round_fwd(fwd_sum_t v);
    fwd_sum_t t;
    t = v + FWD_HALF;
    return t[FWD_SHIFT+15:FWD_SHIFT];
  endfunction

  // Clamp to 0..255 in 22-bit fraction units, then round half up.
  function automatic logic [7:0] clamp_inv(inv_sum_t v);
    inv_sum_t t;
    t = v + INV_HALF;
    if (v < 0) begin
      return 8'd0;
    end else if (v > INV_TOP) begin
      return 8'hFF;
    end else begin
      return t[INV_SHIFT+7:INV_SHIFT];
    end
  endfunction

  // Pick the channels of the active direction; the others read as zero.
  always_comb begin
    pix_next       = '0;
    pix_next.alpha = ctl_in.alpha;
    if (ctl_in.dir == DIR_FWD) begin
      pix_next.luma      = round_fwd(sum_in.luma);
      pix_next.blue_diff = round_fwd(sum_in.blue_diff);
      pix_next.red_diff  = round_fwd(sum_in.red_diff);
    end else begin
      pix_next.red   = clamp_inv(sum_in.red);
      pix_next.green = clamp_inv(sum_in.green);
      pix_next.blue  = clamp_inv(sum_in.blue);
    end
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= ctl_in.valid;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (adv) begin
      pix <= pix_next;
    end
  end

  assign out_valid = valid;
  assign pix_out   = pix;

endmodule

`default_nettype wire

### verif/bt709_color_space_converter_test.sv
// Self-checking testbench for the Rec.709 color space converter, both directions.
module bt709_color_space_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btcsc_pkg::*;

  // Q2.14 coefficients of the conversion matrices, kept apart from the design's own copy.
  localparam longint LUMA_R = 3483;
  localparam longint LUMA_G = 11718;
  localparam longint LUMA_B = 1183;
  localparam longint CB_FROM_R = -1877;
  localparam longint CB_FROM_G = -6315;
  localparam longint CB_FROM_B = 8192;
  localparam longint CR_FROM_R = 8192;
  localparam longint CR_FROM_G = -7441;
  localparam longint CR_FROM_B = -751;
  localparam longint RED_FROM_CR = 25802;
  localparam longint GREEN_FROM_CB = -3069;
  localparam longint GREEN_FROM_CR = -7669;
  localparam longint BLUE_FROM_CB = 30402;
  localparam longint UNIT_GAIN = 16384;

  localparam int PIPE_LATENCY = 3;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_WORDS = 75;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wen;
  logic cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [79:0] m_axis_tdata;

  // Expected output words in order of acceptance.
  pix_out_t expected_pixels[$];
  logic cur_direction;
  int mismatch_count = 0;
  bit no_stalls = 1'b0;
  int sink_hold_cycles = 0;

  bt709_color_space_converter dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Q2.14 sum with 14 fraction bits down to 8, rounding ties upward.
  function automatic logic [15:0] round_to_q8(longint acc);
    longint scaled;
    scaled = (acc + 32) >>> 6;
    return scaled[15:0];
  endfunction

  // Sum with 22 fraction bits, saturated to 0..255 and rounded half up.
  function automatic logic [7:0] saturate_to_byte(longint acc);
    longint top;
    longint scaled;
    top = longint'(255) << 22;
    if (acc < 0) acc = 0;
    if (acc > top) acc = top;
    scaled = (acc + (longint'(1) << 21)) >>> 22;
    return scaled[7:0];
  endfunction

  // Expected output word for one pixel under the given direction.
  function automatic pix_out_t convert_pixel(pix_in_t px, logic dir);
    pix_out_t res;
    longint r, g, b, y, cb, cr;
    res = '0;
    res.alpha = px.alpha;
    if (dir == DIR_FWD) begin
      r = longint'(px.red);
      g = longint'(px.green);
      b = longint'(px.blue);
      res.luma = round_to_q8(LUMA_R * r + LUMA_G * g + LUMA_B * b);
      res.blue_diff = round_to_q8(CB_FROM_R * r + CB_FROM_G * g + CB_FROM_B * b);
      res.red_diff = round_to_q8(CR_FROM_R * r + CR_FROM_G * g + CR_FROM_B * b);
    end else begin
      y = longint'(px.luma) * UNIT_GAIN;
      cb = longint'($signed(px.blue_diff));
      cr = longint'($signed(px.red_diff));
      res.red = saturate_to_byte(y + RED_FROM_CR * cr);
      res.green = saturate_to_byte(y + GREEN_FROM_CB * cb + GREEN_FROM_CR * cr);
      res.blue = saturate_to_byte(y + BLUE_FROM_CB * cb);
    end
    return res;
  endfunction

  // Idle length: mostly short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Sends one word after an optional idle gap; returns at the falling edge after acceptance.
  task automatic send_pixel(pix_in_t px, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    do @(posedge clk); while (!s_axis_tready);
    expected_pixels.push_back(convert_pixel(px, cur_direction));
    @(negedge clk);
  endtask

  // Random sender gap: none during steady stretches, otherwise about half the time.
  function automatic int sender_gap();
    if (no_stalls || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_direction(logic dir);
    cfg_wen <= 1'b1;
    cfg_wdata <= dir;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cur_direction = dir;
  endtask

  function automatic pix_in_t random_pixel();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return pix_in_t'(raw[79:0]);
  endfunction

  // Random pixel that stays mostly in the video range, so the inverse path is not always clamped.
  function automatic pix_in_t video_pixel();
    pix_in_t px;
    int cb, cr;
    px = random_pixel();
    px.luma = 16'($urandom_range(16 * 256, 235 * 256));
    cb = int'($urandom_range(0, 224 * 256)) - 112 * 256;
    cr = int'($urandom_range(0, 224 * 256)) - 112 * 256;
    px.blue_diff = 16'(cb);
    px.red_diff = 16'(cr);
    return px;
  endfunction

  function automatic pix_in_t make_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic [7:0] a);
    pix_in_t px;
    px = random_pixel();
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    return px;
  endfunction

  function automatic pix_in_t make_ycc(logic [15:0] y, logic [15:0] cb, logic [15:0] cr,
                                       logic [7:0] a);
    pix_in_t px;
    px = random_pixel();
    px.luma = y;
    px.blue_diff = cb;
    px.red_diff = cr;
    px.alpha = a;
    return px;
  endfunction

  // Forward corners: black, white, primaries, yellow and cyan, mid gray, alpha extremes.
  task automatic test_forward_corners();
    write_direction(DIR_FWD);
    send_pixel(make_rgb(8'h00, 8'h00, 8'h00, 8'h00), 0);
    send_pixel(make_rgb(8'hff, 8'hff, 8'hff, 8'hff), 0);
    send_pixel(make_rgb(8'hff, 8'h00, 8'h00, 8'h5a), 0);
    send_pixel(make_rgb(8'h00, 8'hff, 8'h00, 8'ha5), 2);
    send_pixel(make_rgb(8'h00, 8'h00, 8'hff, 8'h01), 0);
    send_pixel(make_rgb(8'h80, 8'h80, 8'h80, 8'h80), 0);
    send_pixel(make_rgb(8'hff, 8'hff, 8'h00, 8'hfe), 1);
    send_pixel(make_rgb(8'h00, 8'hff, 8'hff, 8'h7f), 0);
    wait_for_drain();
  endtask

  // Inverse corners: half-up ties, clamping at both ends, field extremes.
  task automatic test_inverse_corners();
    write_direction(DIR_INV);
    send_pixel(make_ycc(16'h0000, 16'h0000, 16'h0000, 8'h00), 0);
    send_pixel(make_ycc(16'h0080, 16'h0000, 16'h0000, 8'hff), 0);
    send_pixel(make_ycc(16'h0180, 16'h0000, 16'h0000, 8'h11), 0);
    send_pixel(make_ycc(16'h007f, 16'h0000, 16'h0000, 8'h22), 3);
    send_pixel(make_ycc(16'hffff, 16'h0000, 16'h0000, 8'h33), 0);
    send_pixel(make_ycc(16'h0000, 16'h8000, 16'h8000, 8'h44), 0);
    send_pixel(make_ycc(16'h0000, 16'h7fff, 16'h7fff, 8'h55), 0);
    send_pixel(make_ycc(16'hffff, 16'h8000, 16'h7fff, 8'h66), 1);
    send_pixel(make_ycc(16'h8000, 16'h7fff, 16'h8000, 8'h77), 0);
    send_pixel(make_ycc(16'heb00, 16'h0000, 16'h0000, 8'h88), 0);
    send_pixel(make_ycc(16'h1000, 16'h7000, 16'h9000, 8'h99), 0);
    send_pixel(make_ycc(16'h7e00, 16'hff00, 16'h0100, 8'haa), 0);
    wait_for_drain();
  endtask

  // The receiver holds off while words keep coming, so the pipeline fills and stalls its input.
  task automatic test_receiver_hold();
    write_direction(DIR_FWD);
    sink_hold_cycles = 120;
    for (int i = 0; i < 12; i++) send_pixel(random_pixel(), 0);
    wait_for_drain();
    write_direction(DIR_INV);
    sink_hold_cycles = 80;
    for (int i = 0; i < 12; i++) send_pixel(video_pixel(), 0);
    wait_for_drain();
  endtask

  // Phases of random words; the sender pauses for a full drain between phases,
  // and the direction is set anew there; the first two phases cover both directions.
  task automatic test_random_traffic();
    logic dir;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      dir = (phase < 2) ? logic'(phase[0]) : logic'($urandom_range(0, 1));
      write_direction(dir);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 25 == 0) no_stalls = ($urandom_range(0, 3) == 0);
        if (dir == DIR_INV && $urandom_range(0, 2) != 0) send_pixel(video_pixel(), sender_gap());
        else send_pixel(random_pixel(), sender_gap());
      end
      no_stalls = 1'b0;
      wait_for_drain();
    end
  endtask

  // Receiver ready: forced hold-offs first, then random stalls.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left > 0 && !no_stalls) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = 0;
        if (!no_stalls && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each output word with the oldest expectation.
  initial begin
    pix_out_t got;
    pix_out_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got = pix_out_t'(m_axis_tdata);
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected word, low bits", m_axis_tdata[15:0], 16'h0);
        end else begin
          want = expected_pixels.pop_front();
          check_field("luma", got.luma, want.luma);
          check_field("blue_diff", got.blue_diff, want.blue_diff);
          check_field("red_diff", got.red_diff, want.red_diff);
          check_field("red", 16'(got.red), 16'(want.red));
          check_field("green", 16'(got.green), 16'(want.green));
          check_field("blue", 16'(got.blue), 16'(want.blue));
          check_field("alpha", 16'(got.alpha), 16'(want.alpha));
        end
      end
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cur_direction = DIR_FWD;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_forward_corners();
    test_inverse_corners();
    test_receiver_hold();
    test_random_traffic();

    // Let any stray word show up before the verdict.
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
